### src/egacc_pkg.sv
// Shared constants, codes and types for the embedding gradient accumulator.
package egacc_pkg;

	localparam int VOCAB_MAX_DEF = 1024;
	localparam int DIM_MAX_DEF   = 64;

	localparam int ROWS_W = 17;
	localparam int COLS_W = 11;
	localparam int VOCAB_CFG_W = 11;
	localparam int DIM_CFG_W   = 7;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_IDX_W   = 2;

	localparam logic [31:0] FP_ZERO      = 32'h0000_0000;
	localparam logic [31:0] FP_QNAN_DEF  = 32'hFFC0_0000;
	localparam logic [31:0] FP_QUIET_BIT = 32'h0040_0000;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_ACC   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_ID  = 2'd1,
		STAT_BAD_COL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOCAB = 2'd0,
		CFG_DIM   = 2'd1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ISSUE,
		ST_FETCH,
		ST_ADD
	} state_t;

endpackage

### src/egacc_ram.sv
// Generic simple dual-port RAM with registered read.
module egacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/egacc_fadd.sv
// Pipelined IEEE single-precision adder, three register stages, round to nearest even.
module egacc_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        out_valid,
	output logic [31:0] sum
);

	// stage 1: unpack, specials, order by magnitude
	logic        v_s1, spec_s1, sx_s1, sub_s1;
	logic [31:0] specv_s1;
	logic [7:0]  e_s1, d_s1;
	logic [23:0] mx_s1, my_s1;

	logic        spec_c;
	logic [31:0] specv_c, x_c, y_c;
	logic [7:0]  exe_c, eye_c;
	logic        a_nan, b_nan, a_inf, b_inf;

	always_comb begin
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		spec_c  = 1'b1;
		specv_c = egacc_pkg::FP_ZERO;
		if (a_nan) begin
			specv_c = a | egacc_pkg::FP_QUIET_BIT;
		end else if (b_nan) begin
			specv_c = b | egacc_pkg::FP_QUIET_BIT;
		end else if (a_inf && b_inf && (a[31] != b[31])) begin
			specv_c = egacc_pkg::FP_QNAN_DEF;
		end else if (a_inf) begin
			specv_c = a;
		end else if (b_inf) begin
			specv_c = b;
		end else begin
			spec_c = 1'b0;
		end
		if (a[30:0] >= b[30:0]) begin
			x_c = a;
			y_c = b;
		end else begin
			x_c = b;
			y_c = a;
		end
		exe_c = (x_c[30:23] == 8'd0) ? 8'd1 : x_c[30:23];
		eye_c = (y_c[30:23] == 8'd0) ? 8'd1 : y_c[30:23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		spec_s1  <= spec_c;
		specv_s1 <= specv_c;
		sx_s1    <= x_c[31];
		sub_s1   <= x_c[31] ^ y_c[31];
		e_s1     <= exe_c;
		d_s1     <= exe_c - eye_c;
		mx_s1    <= {|x_c[30:23], x_c[22:0]};
		my_s1    <= {|y_c[30:23], y_c[22:0]};
	end

	// stage 2: align and add
	logic        v_s2, spec_s2, sx_s2, sub_s2;
	logic [31:0] specv_s2;
	logic [7:0]  e_s2;
	logic [27:0] s_s2;

	logic [26:0] yext_c, xext_c, sh_c, mask_c, al_c;
	logic [27:0] sum_c;

	always_comb begin
		yext_c = {my_s1, 3'b000};
		xext_c = {mx_s1, 3'b000};
		sh_c   = 27'd0;
		mask_c = 27'd0;
		if (d_s1 >= 8'd27) begin
			al_c = {26'd0, |my_s1};
		end else begin
			sh_c   = yext_c >> d_s1;
			mask_c = (27'd1 << d_s1) - 27'd1;
			al_c   = {sh_c[26:1], sh_c[0] | (|(yext_c & mask_c))};
		end
		if (sub_s1) begin
			sum_c = {1'b0, xext_c} - {1'b0, al_c};
		end else begin
			sum_c = {1'b0, xext_c} + {1'b0, al_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		spec_s2  <= spec_s1;
		specv_s2 <= specv_s1;
		sx_s2    <= sx_s1;
		sub_s2   <= sub_s1;
		e_s2     <= e_s1;
		s_s2     <= sum_c;
	end

	// stage 3: leading zero count
	logic        v_s3, spec_s3, sx_s3, sub_s3;
	logic [31:0] specv_s3;
	logic [7:0]  e_s3;
	logic [27:0] s_s3;
	logic [4:0]  lz_s3;
	logic [4:0]  lz_c;

	always_comb begin
		lz_c = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (s_s2[i]) begin
				lz_c = 5'(27 - i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		spec_s3  <= spec_s2;
		specv_s3 <= specv_s2;
		sx_s3    <= sx_s2;
		sub_s3   <= sub_s2;
		e_s3     <= e_s2;
		s_s3     <= s_s2;
		lz_s3    <= lz_c;
	end

	// stage 4: normalize, round, pack
	logic [26:0] m_c;
	logic [9:0]  en_c, expf_c;
	logic [4:0]  lzm1_c, shl_c;
	logic [7:0]  emax_c;
	logic [24:0] mr_c;
	logic [22:0] frac_c;
	logic        up_c;

	always_comb begin
		lzm1_c = lz_s3 - 5'd1;
		emax_c = e_s3 - 8'd1;
		shl_c  = 5'd0;
		if (s_s3[27]) begin
			m_c  = {s_s3[27:2], s_s3[1] | s_s3[0]};
			en_c = {2'b00, e_s3} + 10'd1;
		end else begin
			shl_c = ({3'b000, lzm1_c} > emax_c) ? emax_c[4:0] : lzm1_c;
			m_c   = s_s3[26:0] << shl_c;
			en_c  = {2'b00, e_s3} - {5'd0, shl_c};
		end
		up_c = m_c[2] & (m_c[1] | m_c[0] | m_c[3]);
		mr_c = {1'b0, m_c[26:3]} + {24'd0, up_c};
		if (mr_c[24]) begin
			expf_c = en_c + 10'd1;
			frac_c = 23'd0;
		end else begin
			expf_c = mr_c[23] ? en_c : 10'd0;
			frac_c = mr_c[22:0];
		end
		if (spec_s3) begin
			sum = specv_s3;
		end else if (s_s3 == 28'd0) begin
			sum = {sx_s3 & !sub_s3, 31'd0};
		end else if (expf_c >= 10'd255) begin
			sum = {sx_s3, 8'hFF, 23'd0};
		end else begin
			sum = {sx_s3, expf_c[7:0], frac_c};
		end
	end

	assign out_valid = v_s3;

endmodule

### src/embedding_gradient_accumulator.sv
// Top level: embedding gradient table with float scatter-add and read.
//
//   channel  signals                                     direction
//   in       in_valid/in_ready, kind, entry_id, column,   in
//            grad_value
//   out      out_valid/out_ready, status, read_value      out
//   cfg      cfg_we, cfg_index, cfg_data                  in
//
// Error and no-op items raise out_valid at the accepting edge; reads pass through
// issue and fetch, accumulates through issue, fetch and three adder stages, writing
// back as out_valid rises. Clear and reset sweep the table, writing zeros to all
// VOCAB_MAX*DIM_MAX entries, with in_ready low. One item is in flight; a waiting
// result holds in_ready low until it is taken.
module embedding_gradient_accumulator #(
	parameter int VOCAB_MAX = egacc_pkg::VOCAB_MAX_DEF,
	parameter int DIM_MAX   = egacc_pkg::DIM_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic signed [63:0]                entry_id,
	input  logic [5:0]                        column,
	input  logic [31:0]                       grad_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [31:0]                       read_value,
	input  logic                              cfg_we,
	input  logic [egacc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [egacc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int DEPTH = VOCAB_MAX * DIM_MAX;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = (VOCAB_MAX > 1) ? $clog2(VOCAB_MAX) : 1;
	localparam int RW = egacc_pkg::ROWS_W;
	localparam int CW = egacc_pkg::COLS_W;

	egacc_pkg::state_t state_q, state_d;

	logic [egacc_pkg::VOCAB_CFG_W-1:0] vocab_q;
	logic [egacc_pkg::DIM_CFG_W-1:0]   dim_q;
	logic [AW-1:0]  addr_q, cnt_q, addr_c;
	logic [31:0]    grad_q;
	logic           is_read_q, reply_q;
	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [31:0]    rdval_q;

	logic [RW-1:0]  rows_c;
	logic [CW-1:0]  cols_c;
	logic           id_bad_c, col_bad_c, take_c, sweep_last_c;

	logic           ram_we, ram_re, add_go, add_done;
	logic [AW-1:0]  ram_waddr;
	logic [31:0]    ram_wdata, ram_rdata, add_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= egacc_pkg::VOCAB_CFG_W'(1024);
			dim_q   <= egacc_pkg::DIM_CFG_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				egacc_pkg::CFG_VOCAB: vocab_q <= cfg_data[egacc_pkg::VOCAB_CFG_W-1:0];
				egacc_pkg::CFG_DIM:   dim_q   <= cfg_data[egacc_pkg::DIM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		rows_c = (RW'(vocab_q) > RW'(VOCAB_MAX)) ? RW'(VOCAB_MAX) : RW'(vocab_q);
		cols_c = (CW'(dim_q) > CW'(DIM_MAX)) ? CW'(DIM_MAX) : CW'(dim_q);
		id_bad_c  = entry_id[63] || (entry_id[62:0] >= 63'(rows_c));
		col_bad_c = CW'(column) >= cols_c;
		addr_c = AW'(AW'(entry_id[IW-1:0]) * AW'(DIM_MAX)) + AW'(column);
	end

	assign in_ready = (state_q == egacc_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign take_c = in_valid && in_ready;
	assign sweep_last_c = (cnt_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egacc_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = add_sum;
		ram_re    = 1'b0;
		add_go    = 1'b0;
		unique case (state_q)
			egacc_pkg::ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = egacc_pkg::FP_ZERO;
				if (sweep_last_c) begin
					state_d = egacc_pkg::ST_IDLE;
				end
			end
			egacc_pkg::ST_IDLE: begin
				if (take_c) begin
					if (kind == egacc_pkg::KIND_CLEAR) begin
						state_d = egacc_pkg::ST_SWEEP;
					end else if (kind != egacc_pkg::KIND_NOP && !id_bad_c && !col_bad_c) begin
						state_d = egacc_pkg::ST_ISSUE;
					end
				end
			end
			egacc_pkg::ST_ISSUE: begin
				ram_re  = 1'b1;
				state_d = egacc_pkg::ST_FETCH;
			end
			egacc_pkg::ST_FETCH: begin
				if (is_read_q) begin
					state_d = egacc_pkg::ST_IDLE;
				end else begin
					add_go  = 1'b1;
					state_d = egacc_pkg::ST_ADD;
				end
			end
			egacc_pkg::ST_ADD: begin
				if (add_done) begin
					ram_we  = 1'b1;
					state_d = egacc_pkg::ST_IDLE;
				end
			end
			default: state_d = egacc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			reply_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == egacc_pkg::ST_SWEEP) begin
				cnt_q <= cnt_q + AW'(1);
				if (sweep_last_c) begin
					cnt_q   <= '0;
					reply_q <= 1'b0;
					if (reply_q) begin
						out_valid_q <= 1'b1;
					end
				end
			end
			if (take_c) begin
				if (kind == egacc_pkg::KIND_CLEAR) begin
					reply_q <= 1'b1;
				end else if (kind == egacc_pkg::KIND_NOP || id_bad_c || col_bad_c) begin
					out_valid_q <= 1'b1;
				end
			end
			if (state_q == egacc_pkg::ST_FETCH && is_read_q) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == egacc_pkg::ST_ADD && add_done) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_c) begin
			addr_q    <= addr_c;
			grad_q    <= grad_value;
			is_read_q <= (kind == egacc_pkg::KIND_READ);
			rdval_q   <= egacc_pkg::FP_ZERO;
			if (kind == egacc_pkg::KIND_CLEAR || kind == egacc_pkg::KIND_NOP) begin
				status_q <= egacc_pkg::STAT_OK;
			end else if (id_bad_c) begin
				status_q <= egacc_pkg::STAT_BAD_ID;
			end else if (col_bad_c) begin
				status_q <= egacc_pkg::STAT_BAD_COL;
			end else begin
				status_q <= egacc_pkg::STAT_OK;
			end
		end
		if (state_q == egacc_pkg::ST_FETCH && is_read_q) begin
			rdval_q <= ram_rdata;
		end
	end

	egacc_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	egacc_fadd u_fadd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (add_go),
		.a         (ram_rdata),
		.b         (grad_q),
		.out_valid (add_done),
		.sum       (add_sum)
	);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = rdval_q;

endmodule
